// ----- rtl/sorted_line_number_search_defines.svh -----
// Shared assertion macros for the line table search.
`ifndef SORTED_LINE_NUMBER_SEARCH_DEFINES_SVH
`define SORTED_LINE_NUMBER_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SLS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/sls_pkg.sv -----
`default_nettype none

package sls_pkg;

  localparam int LINE_W  = 14;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [LINE_W-1:0] line_number;
  } sls_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } sls_res_t;

endpackage

`default_nettype wire

// ----- rtl/sls_ram.sv -----
`default_nettype none

module sls_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/sls_engine.sv -----
`default_nettype none

module sls_engine
  import sls_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire sls_req_t                             req,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output sls_res_t                                  res
);

  `include "sorted_line_number_search_defines.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi_ex;
  logic [AW-1:0]     mid;
  logic [LINE_W-1:0] key;
  sls_res_t          hold;

  logic                 accept;
  logic                 we;
  logic [AW-1:0]        addr;
  logic [LINE_W-1:0]    rdata;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic [AW+SLOT_W-1:0] mid_ext;
  logic [CW:0]          span;
  logic [AW-1:0]        mid_calc;
  logic [CW-1:0]        mid_w;
  logic [CW-1:0]        lo_next;
  logic [CW-1:0]        hi_next;
  logic                 hit;
  logic                 out_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;

  assign slot_ext = {{AW{1'b0}}, req.slot};
  assign mid_ext  = {{SLOT_W{1'b0}}, mid};
  assign span     = {1'b0, lo} + {1'b0, hi_ex} - (CW+1)'(1);
  assign mid_calc = span[AW:1];
  assign mid_w    = CW'(mid);

  assign we   = accept && (req.cmd == CMD_WRITE) && (32'(req.slot) < 32'(TABLE_DEPTH));
  assign addr = (state == ST_PROBE) ? mid_calc : slot_ext[AW-1:0];

  sls_ram #(
    .WIDTH (LINE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (req.line_number),
    .rdata (rdata)
  );

  always_comb begin
    hit     = (rdata == key);
    lo_next = lo;
    hi_next = hi_ex;
    if (rdata < key) begin
      lo_next = mid_w + CW'(1);
    end else begin
      hi_next = mid_w;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.cmd == CMD_SEARCH) begin
          state_next = (count == '0) ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: state_next = ST_CMP;
      ST_CMP: begin
        state_next = (hit || lo_next >= hi_next) ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key   <= req.line_number;
      lo    <= '0;
      hi_ex <= count;
      hold  <= '0;
    end
    if (state == ST_PROBE) begin
      mid <= mid_calc;
    end
    if (state == ST_CMP) begin
      lo    <= lo_next;
      hi_ex <= hi_next;
      if (hit) begin
        hold.found    <= 1'b1;
        hold.position <= mid_ext[SLOT_W-1:0];
      end
    end
    if (state == ST_FINISH && out_free) begin
      res <= hold;
    end
  end

  `SLS_ASSERT_NOW(a_probe_in_range, state == ST_PROBE, lo < hi_ex,
    "probe issued on an empty range")
  `SLS_ASSERT_NEXT(a_hi_shrinks, state == ST_CMP, hi_ex <= $past(hi_ex),
    "upper bound grew during search")
  `SLS_ASSERT_NOW(a_miss_zero_pos, res_valid && !res.found, res.position == '0,
    "miss beat carries nonzero position")
  `SLS_ASSERT_NOW(a_result_from_finish, $rose(res_valid), $past(state) == ST_FINISH,
    "result raised outside finish")

endmodule

`default_nettype wire

// ----- rtl/sorted_line_number_search.sv -----
// Write beat: stored in the table on the edge that accepts it, no result.
// Search beat: each probe is a read, then a compare; at most floor(log2(n))+1 probes,
//   n = min(line_count, TABLE_DEPTH); the result is registered as the engine leaves
//   its finish state, and no new beat is taken until the engine is back in idle.
// A previous result not yet taken (out_ready low) stalls the search in its finish state.
// Reset (rst, sync): line_count to 0, engine idle, no result; table kept, undefined.
`default_nettype none

module sorted_line_number_search
  import sls_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] line_count,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic [SLOT_W-1:0]  slot,
  input  wire logic [LINE_W-1:0]  line_number,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [SLOT_W-1:0]       position
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0] count_reg;
  logic [17:0]        count_ext;
  logic [17:0]        count_sat;
  logic [CW-1:0]      count;
  sls_req_t           req;
  sls_res_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_reg <= line_count;
    end
  end

  assign count_ext = 18'(count_reg);
  assign count_sat = (count_ext > 18'(TABLE_DEPTH)) ? 18'(TABLE_DEPTH) : count_ext;
  assign count     = count_sat[CW-1:0];

  assign req.cmd         = cmd;
  assign req.slot        = slot;
  assign req.line_number = line_number;

  sls_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .count     (count),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign found    = res.found;
  assign position = res.position;

endmodule

`default_nettype wire
